// ----- design/i2cmbs_pkg.sv -----
// Package for the I2C master bit sequencer: command codes, field widths,
// per-command step counts. No dependencies.
`default_nettype none

package i2cmbs_pkg;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int STEP_W = 5;
    localparam int PH_W   = 2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RECV  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RACK  = 3'd6;

    localparam logic [PH_W-1:0] PH_DRIVE = 2'd0;
    localparam logic [PH_W-1:0] PH_HIGH  = 2'd1;
    localparam logic [PH_W-1:0] PH_LOW   = 2'd2;

    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    // Number of pin steps taken by each command.
    function automatic logic [STEP_W-1:0] seq_len(input logic [MODE_W-1:0] cmd);
        logic [STEP_W-1:0] len;
        begin
            case (cmd)
                MODE_START: len = STEP_W'(4);
                MODE_STOP:  len = STEP_W'(3);
                MODE_SEND:  len = STEP_W'(24);
                MODE_RECV:  len = STEP_W'(25);
                MODE_SACK:  len = STEP_W'(3);
                MODE_RACK:  len = STEP_W'(4);
                default:    len = STEP_W'(0);
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/i2c_master_bit_sequencer_core.sv -----
// I2C master bit sequencer top level: command/tick stream in, line state out.
// Depends on i2cmbs_pkg.
`default_nettype none

// One beat in, one beat out. Each beat is a command (arms the sequencer) or a
// tick (one SCL write, SDA write or SDA sample of the armed command). Each beat
// is processed combinationally, and its result is in the single output register on
// the next cycle. A new beat is taken every cycle while the output side is
// ready. A result that waits in the output register holds the input until it
// is taken. Commands that arrive while busy come back with rejected set.
module i2c_master_bit_sequencer_core
    import i2cmbs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tx_byte[7:0], ack_out[8], sda_in[9], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  wire logic [MODE_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], rx_byte[11:4],
    // rx_ack[12], rejected[13], zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_out;
    logic              sda_in;
    logic              accept;

    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [MODE_W-1:0] cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              ack_reg, ack_next;
    logic              busy_reg, busy_next;

    logic              done_c;
    logic              rej_c;
    logic [BYTE_W-1:0] rxb_c;
    logic              rxa_c;
    logic [PH_W-1:0]   phase_inc;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign mode    = s_axis_tuser;
    assign tx_byte = s_axis_tdata[BYTE_W-1:0];
    assign ack_out = s_axis_tdata[BYTE_W];
    assign sda_in  = s_axis_tdata[BYTE_W+1];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign phase_inc = (phase_reg == PH_LOW) ? PH_DRIVE : phase_reg + PH_W'(1);

    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        ack_next   = ack_reg;
        busy_next  = busy_reg;
        done_c     = 1'b0;
        rej_c      = 1'b0;
        rxb_c      = '0;
        rxa_c      = 1'b0;

        if (mode == MODE_TICK)
        begin
            if (busy_reg)
            begin
                case (cmd_reg)
                    MODE_START:
                    begin
                        if (step_reg == STEP_W'(0))      sda_next = 1'b1;
                        else if (step_reg == STEP_W'(1)) scl_next = 1'b1;
                        else if (step_reg == STEP_W'(2)) sda_next = 1'b0;
                        else                             scl_next = 1'b0;
                    end
                    MODE_STOP:
                    begin
                        if (step_reg == STEP_W'(0))      sda_next = 1'b0;
                        else if (step_reg == STEP_W'(1)) scl_next = 1'b1;
                        else                             sda_next = 1'b1;
                    end
                    MODE_SEND:
                    begin
                        if (phase_reg == PH_DRIVE)     sda_next = shift_reg[BYTE_W-1];
                        else if (phase_reg == PH_HIGH) scl_next = 1'b1;
                        else
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        end
                    end
                    MODE_RECV:
                    begin
                        if (step_reg == STEP_W'(0))    sda_next = 1'b1;
                        else if (phase_reg == PH_DRIVE) scl_next = 1'b1;
                        else if (phase_reg == PH_HIGH)
                            shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                        else                           scl_next = 1'b0;
                    end
                    MODE_SACK:
                    begin
                        if (step_reg == STEP_W'(0))      sda_next = shift_reg[BYTE_W-1];
                        else if (step_reg == STEP_W'(1)) scl_next = 1'b1;
                        else                             scl_next = 1'b0;
                    end
                    MODE_RACK:
                    begin
                        if (step_reg == STEP_W'(0))      sda_next = 1'b1;
                        else if (step_reg == STEP_W'(1)) scl_next = 1'b1;
                        else if (step_reg == STEP_W'(2)) ack_next = sda_in;
                        else                             scl_next = 1'b0;
                    end
                    default: ;
                endcase

                // receive byte holds its bit phase through the SDA release step
                if (cmd_reg == MODE_RECV && step_reg == STEP_W'(0))
                    phase_next = PH_DRIVE;
                else
                    phase_next = phase_inc;

                step_next = step_reg + STEP_W'(1);
                if (step_next >= seq_len(cmd_reg))
                begin
                    done_c     = 1'b1;
                    busy_next  = 1'b0;
                    cmd_next   = MODE_TICK;
                    step_next  = '0;
                    phase_next = PH_DRIVE;
                    if (cmd_reg == MODE_RECV) rxb_c = shift_next;
                    if (cmd_reg == MODE_RACK) rxa_c = ack_next;
                end
            end
        end
        else if (mode inside {[MODE_START:MODE_RACK]})
        begin
            if (busy_reg)
                rej_c = 1'b1;
            else
            begin
                cmd_next   = mode;
                step_next  = '0;
                phase_next = PH_DRIVE;
                busy_next  = 1'b1;
                case (mode)
                    MODE_SEND: shift_next = tx_byte;
                    MODE_RECV: shift_next = '0;
                    MODE_SACK: shift_next = ack_out ? MSB_MASK : '0;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            cmd_reg       <= MODE_TICK;
            step_reg      <= '0;
            phase_reg     <= PH_DRIVE;
            shift_reg     <= '0;
            ack_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                cmd_reg   <= cmd_next;
                step_reg  <= step_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                ack_reg   <= ack_next;
                busy_reg  <= busy_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {2'b00, rej_c, rxa_c, rxb_c, done_c, busy_next,
                             sda_next, scl_next};
    end

    a_busy_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cmd_reg != MODE_TICK))
        else $error("busy without an active command");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg < seq_len(cmd_reg)))
        else $error("step counter past end of sequence");

    a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_c) |=> (!busy_reg && out_data_reg[3] && !out_data_reg[2]))
        else $error("finished command left block busy");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rej_c) |=> ($stable(step_reg) && $stable(cmd_reg) && busy_reg))
        else $error("rejected command changed sequencer state");

endmodule

`default_nettype wire
